>>> rtl/core/dts_pkg.sv
// Package for the dual token bucket shaper: item structs, configuration
// register set, controller state and command/status types, fixed constants.
// No dependencies.
package dts_pkg;

  localparam int unsigned NowW    = 48;
  localparam int unsigned WaitW   = 48;
  localparam int unsigned BurstW  = 24;
  localparam int unsigned MtuW    = 16;
  localparam int unsigned PktW    = 16;
  localparam int unsigned RateW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned RefillW = 26;

  localparam logic [RefillW-1:0] REFILL_CAP = 26'h2000000;
  localparam logic [63:0]        ROUND_HALF = 64'h8000;
  localparam logic [63:0]        ROUND_UP   = 64'hFFFF;

  localparam logic [BurstW-1:0] BURST_RST = 24'd125000;
  localparam logic [MtuW-1:0]   MTU_RST   = 16'd1500;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BURST    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MTU      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RATE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PEAK     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TPB_RATE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TPB_PEAK = 3'd5;

  typedef struct packed {
    logic [NowW-1:0] now_ticks;
    logic [PktW-1:0] packet_bytes;
  } in_item_t;

  typedef struct packed {
    logic              release_res;
    logic [WaitW-1:0]  wait_ticks;
    logic [BurstW-1:0] committed_level;
    logic [MtuW-1:0]   peak_level;
  } out_item_t;

  typedef struct packed {
    logic [BurstW-1:0] burst;
    logic [MtuW-1:0]   mtu;
    logic [RateW-1:0]  rate;
    logic [RateW-1:0]  peak;
    logic [RateW-1:0]  tpb_rate;
    logic [RateW-1:0]  tpb_peak;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_REFILL,
    ST_EVAL,
    ST_MUL_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic refill;
    logic eval;
    logic mul_wait;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic released;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/dual_token_bucket_shaper.sv
// Top level of the dual token bucket shaper: config registers, sequencing
// FSM and datapath. Depends on dts_pkg, dts_cfg_regs, dts_ctrl, dts_datapath.
//
// One dequeue attempt at a time. From its acceptance to its result entering
// the output register, an attempt takes two passes of the 32x32 refill
// multipliers (elapsed low and high word), a refill rounding step, the
// bucket evaluation, a pass of the same multipliers for the wait, and
// writeback. The result register lets the next attempt be accepted while a
// result still waits; writeback stalls only if that result is still held.
// Rates and reciprocals are Q16.16; a peak rate of zero disables the peak
// bucket. The checkpoint is TIME_BITS wide and the elapsed time wraps at it.
module dual_token_bucket_shaper #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dts_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dts_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dts_pkg::CfgW-1:0]     cfg_data_i
);

  dts_pkg::cfg_t    cfg;
  dts_pkg::cmd_t    cmd;
  dts_pkg::status_t status;

  dts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dts_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/dts_cfg_regs.sv
// Configuration register file of the dual token bucket shaper.
// Depends on dts_pkg.
module dts_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dts_pkg::CfgW-1:0]      cfg_data_i,
  output dts_pkg::cfg_t                 cfg_o
);

  dts_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dts_pkg::CFG_BURST:    cfg_d.burst    = cfg_data_i[dts_pkg::BurstW-1:0];
        dts_pkg::CFG_MTU:      cfg_d.mtu      = cfg_data_i[dts_pkg::MtuW-1:0];
        dts_pkg::CFG_RATE:     cfg_d.rate     = cfg_data_i;
        dts_pkg::CFG_PEAK:     cfg_d.peak     = cfg_data_i;
        dts_pkg::CFG_TPB_RATE: cfg_d.tpb_rate = cfg_data_i;
        dts_pkg::CFG_TPB_PEAK: cfg_d.tpb_peak = cfg_data_i;
        default:               cfg_d = cfg_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst    <= dts_pkg::BURST_RST;
      cfg_q.mtu      <= dts_pkg::MTU_RST;
      cfg_q.rate     <= '0;
      cfg_q.peak     <= '0;
      cfg_q.tpb_rate <= '0;
      cfg_q.tpb_peak <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/dts_ctrl.sv
// Sequencing FSM of the dual token bucket shaper: steps one transaction
// through the datapath. Depends on dts_pkg.
module dts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dts_pkg::status_t status_i,
  output dts_pkg::cmd_t    cmd_o
);

  dts_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dts_pkg::ST_IDLE:     if (in_valid_i) state_d = dts_pkg::ST_MUL_LO;
      dts_pkg::ST_MUL_LO:   state_d = dts_pkg::ST_MUL_HI;
      dts_pkg::ST_MUL_HI:   state_d = dts_pkg::ST_REFILL;
      dts_pkg::ST_REFILL:   state_d = dts_pkg::ST_EVAL;
      dts_pkg::ST_EVAL:     state_d = dts_pkg::ST_MUL_WAIT;
      dts_pkg::ST_MUL_WAIT: state_d = dts_pkg::ST_DONE;
      dts_pkg::ST_DONE:     if (status_i.out_free) state_d = dts_pkg::ST_IDLE;
      default:              state_d = dts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      dts_pkg::ST_MUL_LO:   cmd_o.mul_lo   = 1'b1;
      dts_pkg::ST_MUL_HI:   cmd_o.mul_hi   = 1'b1;
      dts_pkg::ST_REFILL:   cmd_o.refill   = 1'b1;
      dts_pkg::ST_EVAL:     cmd_o.eval     = 1'b1;
      dts_pkg::ST_MUL_WAIT: cmd_o.mul_wait = 1'b1;
      dts_pkg::ST_DONE:     cmd_o.commit   = status_i.out_free;
      default:              cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a held result stalls the writeback step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dts_pkg::ST_DONE && !status_i.out_free |=> state_q == dts_pkg::ST_DONE)
    else $error("writeback left while output slot busy");

  // an accepted transaction always starts the low multiply next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == dts_pkg::ST_MUL_LO)
    else $error("accepted transaction did not start");

endmodule

>>> rtl/core/dts_datapath.sv
// Datapath of the dual token bucket shaper: two multiplier lanes (committed,
// peak), bucket state, checkpoint and output register. Depends on dts_pkg.
module dts_datapath #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dts_pkg::cmd_t       cmd_i,
  output dts_pkg::status_t    status_o,
  input  dts_pkg::cfg_t       cfg_i,
  input  dts_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dts_pkg::out_item_t  out_data_o
);

  localparam int unsigned BW = dts_pkg::BurstW;
  localparam int unsigned MW = dts_pkg::MtuW;
  localparam int unsigned RW = dts_pkg::RefillW;

  // bucket state
  logic [TIME_BITS-1:0] ckpt_q;
  logic [BW-1:0]        tok_c_q;
  logic [MW-1:0]        tok_p_q;

  // per-transaction working registers
  logic [TIME_BITS-1:0]      now_q, elapsed_q;
  logic [dts_pkg::PktW-1:0]  pkt_q;
  logic [63:0]               prod_c_q, prod_p_q;
  logic [47:0]               rnd_c_q, rnd_p_q;
  logic [RW-1:0]             fill_c_q, fill_p_q;
  logic signed [BW:0]        bt_q;
  logic signed [MW:0]        pt_q;
  logic                      short_c_q, short_p_q;

  logic                      out_valid_q;
  dts_pkg::out_item_t        out_q, out_d;

  logic [63:0]           now64, el64;
  logic [TIME_BITS-1:0]  now_tb;
  logic [31:0]           op_c, op_p, opb_c, opb_p;
  logic [63:0]           rfull_c, rfull_p;
  logic [48:0]           sum_c, sum_p;
  logic [RW-1:0]         fill_c_d, fill_p_d;
  logic [RW-1:0]         t_c, t_p;
  logic [BW-1:0]         tc_clamp;
  logic [MW-1:0]         tp_clamp;
  logic                  peak_on;
  logic [BW:0]           neg_c;
  logic [MW:0]           neg_p;
  logic [63:0]           wfull_c, wfull_p;
  logic [32:0]           wait_c, wait_p, wait_max;
  logic                  released;

  assign now64   = 64'(in_data_i.now_ticks);
  assign now_tb  = now64[TIME_BITS-1:0];
  assign el64    = 64'(elapsed_q);
  assign peak_on = cfg_i.peak != '0;
  assign neg_c   = -bt_q;
  assign neg_p   = -pt_q;

  // shared multiplier operands: elapsed low word, elapsed high word, deficit
  always_comb begin
    if (cmd_i.mul_wait) begin
      op_c  = 32'(neg_c[MW-1:0]);
      op_p  = 32'(neg_p[MW-1:0]);
      opb_c = cfg_i.tpb_rate;
      opb_p = cfg_i.tpb_peak;
    end else begin
      op_c  = cmd_i.mul_hi ? el64[63:32] : el64[31:0];
      op_p  = op_c;
      opb_c = cfg_i.rate;
      opb_p = cfg_i.peak;
    end
  end

  // refill = round(elapsed * rate / 2^16), saturated
  assign rfull_c = prod_c_q + dts_pkg::ROUND_HALF;
  assign rfull_p = prod_p_q + dts_pkg::ROUND_HALF;
  assign sum_c   = {17'd0, prod_c_q[15:0], 16'd0} + {1'b0, rnd_c_q};
  assign sum_p   = {17'd0, prod_p_q[15:0], 16'd0} + {1'b0, rnd_p_q};

  always_comb begin
    if (prod_c_q[63:16] != '0 || sum_c > 49'(dts_pkg::REFILL_CAP)) begin
      fill_c_d = dts_pkg::REFILL_CAP;
    end else begin
      fill_c_d = sum_c[RW-1:0];
    end
    if (prod_p_q[63:16] != '0 || sum_p > 49'(dts_pkg::REFILL_CAP)) begin
      fill_p_d = dts_pkg::REFILL_CAP;
    end else begin
      fill_p_d = sum_p[RW-1:0];
    end
  end

  // level + refill, clamped to bucket size
  assign t_c = RW'(tok_c_q) + fill_c_q;
  assign t_p = RW'(tok_p_q) + fill_p_q;
  assign tc_clamp = (t_c > RW'(cfg_i.burst)) ? cfg_i.burst : t_c[BW-1:0];
  assign tp_clamp = (t_p > RW'(cfg_i.mtu))   ? cfg_i.mtu   : t_p[MW-1:0];

  // wait = ceil(deficit * ticks_per_byte / 2^16)
  assign wfull_c  = prod_c_q + dts_pkg::ROUND_UP;
  assign wfull_p  = prod_p_q + dts_pkg::ROUND_UP;
  assign wait_c   = short_c_q ? wfull_c[48:16] : '0;
  assign wait_p   = short_p_q ? wfull_p[48:16] : '0;
  assign wait_max = (wait_c > wait_p) ? wait_c : wait_p;
  assign released = !short_c_q && !short_p_q;

  always_comb begin
    out_d.release_res = released;
    if (released) begin
      out_d.wait_ticks      = '0;
      out_d.committed_level = bt_q[BW-1:0];
      out_d.peak_level      = pt_q[MW-1:0];
    end else begin
      out_d.wait_ticks      = dts_pkg::WaitW'(wait_max);
      out_d.committed_level = tok_c_q;
      out_d.peak_level      = tok_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q     <= now_tb;
      elapsed_q <= now_tb - ckpt_q;
      pkt_q     <= in_data_i.packet_bytes;
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi || cmd_i.mul_wait) begin
      prod_c_q <= 64'(op_c) * 64'(opb_c);
      prod_p_q <= 64'(op_p) * 64'(opb_p);
    end
    if (cmd_i.mul_hi) begin
      rnd_c_q <= rfull_c[63:16];
      rnd_p_q <= rfull_p[63:16];
    end
    if (cmd_i.refill) begin
      fill_c_q <= fill_c_d;
      fill_p_q <= fill_p_d;
    end
    if (cmd_i.eval) begin
      bt_q      <= $signed({1'b0, tc_clamp}) - $signed((BW+1)'(pkt_q));
      pt_q      <= peak_on ? ($signed({1'b0, tp_clamp}) - $signed((MW+1)'(pkt_q))) : '0;
      short_c_q <= tc_clamp < BW'(pkt_q);
      short_p_q <= peak_on && (tp_clamp < pkt_q);
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ckpt_q      <= '0;
      tok_c_q     <= dts_pkg::BURST_RST;
      tok_p_q     <= dts_pkg::MTU_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && released) begin
        ckpt_q  <= now_q;
        tok_c_q <= bt_q[BW-1:0];
        tok_p_q <= pt_q[MW-1:0];
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.released = released;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && released |=> ckpt_q == $past(now_q))
    else $error("checkpoint not moved on release");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && released |=> tok_c_q <= $past(cfg_i.burst))
    else $error("committed bucket above burst size after release");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.release_res |-> out_q.wait_ticks == '0)
    else $error("nonzero wait reported with release");

endmodule

>>> bench/shaper_checker.sv
// Checker for the dual token bucket shaper: watches the attempt, result and
// register channels, predicts each verdict and compares it field by field.
// Depends on dts_pkg.
`timescale 1ns / 1ps

module shaper_checker
  import dts_pkg::*;
#(
  parameter int unsigned TimeBits = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        released_o,
  output int unsigned        errors_o
);

  localparam logic [63:0] TimeMask = (TimeBits >= 64) ? '1 : ((64'd1 << TimeBits) - 64'd1);

  cfg_t              shaper_cfg;
  logic [63:0]       mark_time;
  logic [BurstW-1:0] commit_lvl;
  logic [MtuW-1:0]   peak_lvl;
  out_item_t         verdicts_q[$];
  out_item_t         due;
  int unsigned       released;
  int unsigned       mismatches;

  // round(span * rate / 2^16), halves up, saturated well above any bucket size
  function automatic logic [RefillW-1:0] refill_of(logic [63:0] span, logic [31:0] rate);
    logic [63:0] lo_prod;
    logic [63:0] hi_prod;
    logic [63:0] sum;
    lo_prod = 64'(span[31:0]) * 64'(rate);
    hi_prod = (span >> 32) * 64'(rate);
    if (hi_prod >= 64'h10000) return REFILL_CAP;
    sum = (hi_prod << FracW) + ((lo_prod + ROUND_HALF) >> FracW);
    return (sum > 64'(REFILL_CAP)) ? REFILL_CAP : sum[RefillW-1:0];
  endfunction

  function automatic longint level_after(longint unsigned lvl, longint unsigned fill,
                                         longint unsigned cap, longint unsigned pkt);
    longint unsigned t;
    t = lvl + fill;
    if (t > cap) t = cap;
    return longint'(t) - longint'(pkt);
  endfunction

  function automatic logic [63:0] wait_of(longint left, logic [31:0] tpb);
    logic [63:0] deficit;
    deficit = 64'(-left);
    return (deficit * 64'(tpb) + ROUND_UP) >> FracW;
  endfunction

  // One dequeue attempt: refill, clamp, take the packet off, decide.
  function automatic out_item_t shaper_verdict(in_item_t att);
    logic [63:0] now_t;
    logic [63:0] span;
    longint      c_left;
    longint      p_left;
    logic [63:0] wc;
    logic [63:0] wp;
    out_item_t   r;
    now_t  = 64'(att.now_ticks) & TimeMask;
    span   = (now_t - mark_time) & TimeMask;
    p_left = 0;
    if (shaper_cfg.peak != '0)
      p_left = level_after(peak_lvl, refill_of(span, shaper_cfg.peak), shaper_cfg.mtu,
                           att.packet_bytes);
    c_left = level_after(commit_lvl, refill_of(span, shaper_cfg.rate), shaper_cfg.burst,
                         att.packet_bytes);
    r = '0;
    if (c_left >= 0 && p_left >= 0) begin
      mark_time     = now_t;
      commit_lvl    = c_left[BurstW-1:0];
      peak_lvl      = p_left[MtuW-1:0];
      r.release_res = 1'b1;
      released++;
    end else begin
      wc = (c_left < 0) ? wait_of(c_left, shaper_cfg.tpb_rate) : 64'd0;
      wp = (p_left < 0) ? wait_of(p_left, shaper_cfg.tpb_peak) : 64'd0;
      r.wait_ticks = (wc > wp) ? wc[WaitW-1:0] : wp[WaitW-1:0];
    end
    r.committed_level = commit_lvl;
    r.peak_level      = peak_lvl;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shaper_cfg          = '0;
      shaper_cfg.burst    = BURST_RST;
      shaper_cfg.mtu      = MTU_RST;
      mark_time           = '0;
      commit_lvl          = BURST_RST;
      peak_lvl            = MTU_RST;
      released            = 0;
      mismatches          = 0;
      verdicts_q.delete();
      pending_o  <= 0;
      released_o <= 0;
      errors_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdicts_q.size() == 0) begin
          $error("result transaction with no attempt outstanding");
          mismatches++;
        end else begin
          due = verdicts_q.pop_front();
          if (out_data_i.release_res !== due.release_res) begin
            $error("release_res: expected %0d, actual %0d",
                   due.release_res, out_data_i.release_res);
            mismatches++;
          end
          if (out_data_i.wait_ticks !== due.wait_ticks) begin
            $error("wait_ticks: expected %0d, actual %0d",
                   due.wait_ticks, out_data_i.wait_ticks);
            mismatches++;
          end
          if (out_data_i.committed_level !== due.committed_level) begin
            $error("committed_level: expected %0d, actual %0d",
                   due.committed_level, out_data_i.committed_level);
            mismatches++;
          end
          if (out_data_i.peak_level !== due.peak_level) begin
            $error("peak_level: expected %0d, actual %0d",
                   due.peak_level, out_data_i.peak_level);
            mismatches++;
          end
        end
      end
      // writes only touch the settings, never the bucket levels
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BURST:    shaper_cfg.burst    = cfg_data_i[BurstW-1:0];
          CFG_MTU:      shaper_cfg.mtu      = cfg_data_i[MtuW-1:0];
          CFG_RATE:     shaper_cfg.rate     = cfg_data_i[RateW-1:0];
          CFG_PEAK:     shaper_cfg.peak     = cfg_data_i[RateW-1:0];
          CFG_TPB_RATE: shaper_cfg.tpb_rate = cfg_data_i[RateW-1:0];
          CFG_TPB_PEAK: shaper_cfg.tpb_peak = cfg_data_i[RateW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) verdicts_q.push_back(shaper_verdict(in_data_i));
      pending_o  <= verdicts_q.size();
      released_o <= released;
      errors_o   <= mismatches;
    end
  end

endmodule

>>> bench/tb.sv
// Top of the dual token bucket shaper bench: clock, reset, attempt and
// register stimulus, verdict. Depends on dts_pkg, dual_token_bucket_shaper
// and shaper_checker.
`timescale 1ns / 1ps

module tb;
  import dts_pkg::*;

  localparam int unsigned TimeBits     = 48;
  localparam int unsigned PhaseCount   = 9;
  localparam int unsigned PhaseItems   = 92;
  localparam int unsigned CalmPhase    = 4;
  localparam int unsigned SettleCycles = 8;

  // indexes past the register set; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  int unsigned pending;
  int unsigned released;
  int unsigned errors;
  int unsigned attempts = 0;
  int unsigned settings = 0;
  bit          calm     = 1'b0;
  logic [TimeBits-1:0] clock_now = '0;

  dual_token_bucket_shaper #(.TIME_BITS(TimeBits)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  shaper_checker #(.TimeBits(TimeBits)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .released_o(released), .errors_o(errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 31);

  initial begin
    #5_000_000;
    $display("dual_token_bucket_shaper regression: fail");
    $finish;
  end

  task automatic attempt(logic [TimeBits-1:0] now_t, logic [PktW-1:0] pkt);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.now_ticks    <= now_t;
    in_data_i.packet_bytes <= pkt;
    do @(posedge clk_i); while (!in_ready_o);
    clock_now = now_t;
    attempts++;
  endtask

  // Wait until every result has come back; pending is registered in the checker.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Bits above the burst and MTU widths carry junk to exercise masking.
  task automatic program_regs(cfg_t c);
    drain();
    if ($urandom_range(1)) write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_BURST, {8'($urandom), c.burst});
    write_reg(CFG_MTU, {16'($urandom), c.mtu});
    write_reg(CFG_RATE, c.rate);
    write_reg(CFG_PEAK, c.peak);
    write_reg(CFG_TPB_RATE, c.tpb_rate);
    write_reg(CFG_TPB_PEAK, c.tpb_peak);
    if ($urandom_range(1)) write_reg(CFG_SPARE_HI, $urandom);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [31:0] recip_of(logic [31:0] rate);
    logic [63:0] q;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 15 || rate == 0) return $urandom;
    q = 64'h1_0000_0000 / 64'(rate);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic draw_settings(output cfg_t c, output int unsigned gap,
                               output int unsigned pkt_top);
    int unsigned pick;
    logic [63:0] span;
    pick = $urandom_range(99);
    c.burst = (pick < 5) ? '0 : (pick < 10) ? '1 : (pick < 20) ? BurstW'($urandom) :
              BurstW'($urandom_range(1500, 20000));
    pick = $urandom_range(99);
    c.mtu = (pick < 5) ? '0 : (pick < 10) ? '1 : MtuW'($urandom_range(1500, 9000));
    pick = $urandom_range(99);
    c.rate = (pick < 5) ? '0 : (pick < 10) ? '1 : (pick < 20) ? $urandom :
             $urandom_range(32'h1000, 32'h40000);
    pick = $urandom_range(99);
    c.peak = (pick < 30) ? '0 : (pick < 35) ? '1 : $urandom_range(32'h10000, 32'h200000);
    c.tpb_rate = recip_of(c.rate);
    c.tpb_peak = recip_of(c.peak);
    // time steps sized so a typical step refills about one packet
    span = (c.rate == 0) ? 64'd2000 : (64'd2000 << FracW) / 64'(c.rate);
    gap = (span == 0) ? 1 : (span > 64'd1_000_000) ? 1_000_000 : int'(span);
    pkt_top = $urandom_range(64, 3000);
  endtask

  task automatic random_attempt(int unsigned gap, int unsigned pkt_top);
    logic [TimeBits-1:0] t;
    logic [PktW-1:0]     p;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 50)      t = clock_now + TimeBits'($urandom_range(gap));
    else if (pick < 70) t = clock_now;
    else if (pick < 85) t = clock_now + TimeBits'($urandom_range(gap * 10));
    else if (pick < 92) t = clock_now + {16'($urandom), 32'($urandom)};
    else if (pick < 96) t = clock_now - TimeBits'($urandom_range(1, 4000));  // backwards
    else                t = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(99);
    if (pick < 3)       p = '0;
    else if (pick < 6)  p = '1;
    else if (pick < 16) p = PktW'($urandom);
    else                p = PktW'($urandom_range(1, pkt_top));
    attempt(t, p);
  endtask

  initial begin
    cfg_t        c;
    int unsigned gap;
    int unsigned pkt_top;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // settings out of reset: no refill, no peak bucket, zero reciprocals
    attempt('0, '0);
    attempt('0, '1);
    attempt(48'd1, '1);
    attempt('1, 16'd1);

    // committed level above the new burst, peak bucket empty and short
    program_regs('{burst: 24'd3000, mtu: 16'd1500, rate: 32'h10000, peak: 32'h20000,
                   tpb_rate: 32'h10000, tpb_peak: 32'h8000});
    attempt('1, 16'd1000);
    attempt(48'd499, 16'd1000);
    attempt(48'd499, 16'd3000);
    attempt(48'd10, 16'd1600);
    attempt(48'd10, 16'd1500);
    attempt(48'd11, 16'd1);

    program_regs('{burst: '1, mtu: '1, rate: '1, peak: '1, tpb_rate: '1, tpb_peak: '1});
    attempt(48'd12, '1);
    attempt(48'd12, '1);
    attempt(48'd11, '1);
    attempt(48'd11, '0);

    // empty buckets, half-byte refill, zero and maximal reciprocals
    program_regs('{burst: '0, mtu: '0, rate: 32'h8000, peak: 32'h1, tpb_rate: '0,
                   tpb_peak: '1});
    attempt(48'd100, 16'd1);
    attempt(48'd101, '0);
    attempt(48'd200, 16'd2);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      draw_settings(c, gap, pkt_top);
      program_regs(c);
      calm = (ph == CalmPhase);
      for (int unsigned n = 0; n < PhaseItems; n++) random_attempt(gap, pkt_top);
      calm = 1'b0;
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d dequeue attempts over %0d register settings, %0d released",
             attempts, settings, released);
    if (errors == 0) begin
      $display("dual_token_bucket_shaper regression: pass");
    end else begin
      $display("dual_token_bucket_shaper regression: fail");
    end
    $finish;
  end

endmodule
